// ===== src/frt_pkg.sv =====
package frt_pkg;

  // Result codes carried on the verdict port
  typedef enum logic [2:0] {
    V_WHOLE     = 3'd0,
    V_STARTED   = 3'd1,
    V_APPENDED  = 3'd2,
    V_COMPLETED = 3'd3,
    V_NOSTART   = 3'd4,
    V_ORDER     = 3'd5,
    V_FULL      = 3'd6,
    V_OVERFLOW  = 3'd7
  } verdict_e;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  localparam int unsigned SEQ_LAST = 255;

  // One fragment header as latched from the input channel
  typedef struct packed {
    logic [15:0] message_id;
    logic [15:0] origin_addr;
    logic [7:0]  frag_seq;
    logic [15:0] total_len;
    logic [7:0]  frag_len;
  } item_t;

  // One table entry as stored in the slot memory
  typedef struct packed {
    logic [31:0] key;
    logic [15:0] total;
    logic [15:0] received;
    logic [7:0]  last_seq;
  } ent_t;

  // One result item
  typedef struct packed {
    verdict_e    verdict;
    logic [2:0]  slot_index;
    logic [15:0] write_offset;
    logic [15:0] deliver_len;
  } res_t;

  // Table update requested by the decision logic
  typedef struct packed {
    logic we;
    logic set_valid;
    logic clr_valid;
    ent_t ent;
  } upd_t;

endpackage

// ===== src/frt_ram.sv =====
module frt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one word, read one word with registered output
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/frt_update.sv =====
module frt_update #(
  parameter int unsigned IdxW = 3
) (
  input  frt_pkg::item_t  item_i,
  input  logic            hit_i,
  input  logic [IdxW-1:0] hit_idx_i,
  input  frt_pkg::ent_t   ent_i,
  input  logic            free_found_i,
  input  logic [IdxW-1:0] free_idx_i,
  output frt_pkg::res_t   res_o,
  output frt_pkg::upd_t   upd_o,
  output logic [IdxW-1:0] wr_idx_o
);
  import frt_pkg::*;

  logic [16:0]     sum;
  logic            seq_ok;
  logic [IdxW+2:0] hit_wide;
  logic [IdxW+2:0] free_wide;

  assign sum       = {1'b0, ent_i.received} + {9'b0, item_i.frag_len};
  assign seq_ok    = (ent_i.last_seq != SEQ_LAST[7:0]) &&
                     (item_i.frag_seq == ent_i.last_seq + 8'd1);
  assign hit_wide  = {3'b000, hit_idx_i};
  assign free_wide = {3'b000, free_idx_i};

  // Decide the verdict and the table write for one fragment
  always_comb begin
    res_o              = '0;
    res_o.verdict      = V_NOSTART;
    upd_o              = '0;
    upd_o.ent.key      = {item_i.origin_addr, item_i.message_id};
    upd_o.ent.total    = item_i.total_len;
    upd_o.ent.received = {8'b0, item_i.frag_len};
    upd_o.ent.last_seq = '0;
    wr_idx_o           = free_idx_i;
    if (!hit_i) begin
      priority if (item_i.frag_seq != 8'd0) begin
        res_o.verdict = V_NOSTART;
      end else if ({8'b0, item_i.frag_len} == item_i.total_len) begin
        res_o.verdict     = V_WHOLE;
        res_o.deliver_len = item_i.total_len;
      end else if ({8'b0, item_i.frag_len} > item_i.total_len) begin
        res_o.verdict = V_OVERFLOW;
      end else if (!free_found_i) begin
        res_o.verdict = V_FULL;
      end else begin
        res_o.verdict    = V_STARTED;
        res_o.slot_index = free_wide[2:0];
        upd_o.we         = 1'b1;
        upd_o.set_valid  = 1'b1;
      end
    end else begin
      res_o.slot_index   = hit_wide[2:0];
      wr_idx_o           = hit_idx_i;
      upd_o.ent          = ent_i;
      upd_o.ent.last_seq = item_i.frag_seq;
      upd_o.ent.received = sum[15:0];
      priority if (!seq_ok) begin
        res_o.verdict = V_ORDER;
      end else if (sum > {1'b0, ent_i.total}) begin
        res_o.verdict = V_OVERFLOW;
      end else if (sum[15:0] == ent_i.total) begin
        res_o.verdict      = V_COMPLETED;
        res_o.write_offset = ent_i.received;
        res_o.deliver_len  = ent_i.total;
        upd_o.we           = 1'b1;
        upd_o.clr_valid    = 1'b1;
      end else begin
        res_o.verdict      = V_APPENDED;
        res_o.write_offset = ent_i.received;
        upd_o.we           = 1'b1;
      end
    end
  end

endmodule

// ===== src/fragment_reassembly_tracker.sv =====
// Fragment reassembly tracker.
// Input channel: one fragment header per item (message_id, origin_addr,
// frag_seq, total_len, frag_len), accepted when in_valid_i is high and
// in_stall_o is low. Output channel: one result item per input item
// (verdict, slot_index, write_offset, deliver_len), taken when out_valid_o
// is high and out_stall_i is low.
// The slot table lives in a synchronous RAM, one entry per slot; valid bits
// sit in flip-flops. Each item scans the RAM one slot per cycle, stopping at
// the first matching entry, and then moves to a decide state that writes the
// entry back; a miss scans all SLOTS slots. The input side is busy from
// acceptance through the scan and the decision until it returns to idle;
// the one-slot-per-cycle RAM read sets how long a scan takes.
// One item is in work at a time. A result waits in the output register
// while the receiver stalls; the next item is still accepted and scanned,
// and its decision waits until the register is free.
// Reset clears all valid bits, so the table starts empty; no clearing pass
// runs over the RAM.
module fragment_reassembly_tracker #(
  parameter int unsigned SLOTS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        message_id_i,
  input  logic [15:0]        origin_addr_i,
  input  logic [7:0]         frag_seq_i,
  input  logic [15:0]        total_len_i,
  input  logic [7:0]         frag_len_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output frt_pkg::verdict_e  verdict_o,
  output logic [2:0]         slot_index_o,
  output logic [15:0]        write_offset_o,
  output logic [15:0]        deliver_len_o
);
  import frt_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);
  localparam int unsigned EntW = $bits(ent_t);

  state_e          state_q, state_d;
  item_t           item_q;
  logic [SLOTS-1:0] valid_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q;
  ent_t            ent_q;
  logic            free_found_q;
  logic [IdxW-1:0] free_idx_q;
  logic            out_valid_q;
  res_t            res_q;

  logic            in_fire;
  logic            match;
  logic            scan_done;
  logic            decide_fire;
  logic [EntW-1:0] rdata;
  ent_t            rd_ent;
  res_t            res;
  upd_t            upd;
  logic [IdxW-1:0] wr_idx;

  assign rd_ent      = ent_t'(rdata);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign match       = valid_q[idx_q] &&
                       (rd_ent.key == {item_q.origin_addr, item_q.message_id});
  assign scan_done   = match || (idx_q == LastIdx);

  // Slot table memory
  frt_ram #(
    .Width (EntW),
    .Depth (SLOTS),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (decide_fire && upd.we),
    .waddr_i (wr_idx),
    .wdata_i (upd.ent),
    .raddr_i (idx_d),
    .rdata_o (rdata)
  );

  // Decision logic for the scanned fragment
  frt_update #(
    .IdxW (IdxW)
  ) u_update (
    .item_i       (item_q),
    .hit_i        (hit_q),
    .hit_idx_i    (hit_idx_q),
    .ent_i        (ent_q),
    .free_found_i (free_found_q),
    .free_idx_i   (free_idx_q),
    .res_o        (res),
    .upd_o        (upd),
    .wr_idx_o     (wr_idx)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: read address and decision strobe
  always_comb begin
    idx_d       = idx_q;
    decide_fire = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
      end
      ST_SCAN: begin
        idx_d = scan_done ? '0 : idx_q + 1'b1;
      end
      ST_DECIDE: begin
        decide_fire = !out_valid_q || !out_stall_i;
      end
      default: idx_d = '0;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (decide_fire && upd.set_valid) valid_q[wr_idx] <= 1'b1;
      if (decide_fire && upd.clr_valid) valid_q[wr_idx] <= 1'b0;
      if (decide_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Latch item, track hit and lowest free slot during the scan, register the result
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q       <= '{message_id:  message_id_i,
                        origin_addr: origin_addr_i,
                        frag_seq:    frag_seq_i,
                        total_len:   total_len_i,
                        frag_len:    frag_len_i};
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
    end
    if (state_q == ST_SCAN) begin
      if (match) begin
        hit_q     <= 1'b1;
        hit_idx_q <= idx_q;
        ent_q     <= rd_ent;
      end
      if (!valid_q[idx_q] && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= idx_q;
      end
    end
    if (decide_fire) res_q <= res;
  end

  assign out_valid_o    = out_valid_q;
  assign verdict_o      = res_q.verdict;
  assign slot_index_o   = res_q.slot_index;
  assign write_offset_o = res_q.write_offset;
  assign deliver_len_o  = res_q.deliver_len;

endmodule

// ===== src/frt_checker.sv =====
module frt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input frt_pkg::verdict_e verdict_o,
  input logic [2:0]        slot_index_o,
  input logic [15:0]       write_offset_o,
  input logic [15:0]       deliver_len_o
);
  import frt_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its fields
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i
      |=> $stable({verdict_o, slot_index_o, write_offset_o, deliver_len_o}))
    else $error("result changed while stalled");

  // One item at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted while another is in work");

  // A new result only appears after the block has been busy
  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o && out_stall_i)) |-> $past(in_stall_o))
    else $error("result without an item in work");

  // Only whole and completed messages deliver a length
  a_dlen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (verdict_o != V_WHOLE) && (verdict_o != V_COMPLETED)
      |-> (deliver_len_o == 16'd0))
    else $error("length delivered for a partial message");

endmodule

bind fragment_reassembly_tracker frt_checker u_frt_checker (.*);

// ===== sim/reassembly_checker.sv =====
`timescale 1ns / 1ps

module reassembly_checker #(
  parameter int unsigned SLOTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [15:0]       message_id_i,
  input  logic [15:0]       origin_addr_i,
  input  logic [7:0]        frag_seq_i,
  input  logic [15:0]       total_len_i,
  input  logic [7:0]        frag_len_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  frt_pkg::verdict_e verdict_i,
  input  logic [2:0]        slot_index_i,
  input  logic [15:0]       write_offset_i,
  input  logic [15:0]       deliver_len_i,
  output int                mismatch_count_o,
  output int                outstanding_o,
  output int                checked_o
);
  import frt_pkg::*;

  // Shadow of the reassembly table
  bit        entry_busy  [SLOTS];
  bit [31:0] entry_key   [SLOTS];
  bit [15:0] entry_total [SLOTS];
  bit [15:0] entry_count [SLOTS];
  bit [7:0]  entry_seq   [SLOTS];

  res_t pending_results [$];
  res_t want;

  initial begin
    mismatch_count_o = 0;
    outstanding_o    = 0;
    checked_o        = 0;
  end

  // Work out the result of one fragment header and update the shadow table
  function automatic res_t predict_fragment(input logic [15:0] id, input logic [15:0] org,
                                            input logic [7:0] seq, input logic [15:0] tot,
                                            input logic [7:0] flen);
    res_t      r;
    bit [31:0] key;
    int        hit;
    int        free_slot;
    bit [16:0] sum;
    r         = '0;
    r.verdict = V_WHOLE;
    key       = {org, id};
    hit       = -1;
    free_slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && entry_busy[i] && entry_key[i] == key) hit = i;
      if (free_slot < 0 && !entry_busy[i]) free_slot = i;
    end
    if (hit < 0) begin
      if (seq != 8'd0) begin
        r.verdict = V_NOSTART;
      end else if (flen == tot) begin
        r.verdict     = V_WHOLE;
        r.deliver_len = tot;
      end else if (flen > tot) begin
        r.verdict = V_OVERFLOW;
      end else if (free_slot < 0) begin
        r.verdict = V_FULL;
      end else begin
        entry_busy[free_slot]  = 1'b1;
        entry_key[free_slot]   = key;
        entry_total[free_slot] = tot;
        entry_count[free_slot] = flen;
        entry_seq[free_slot]   = 8'd0;
        r.verdict              = V_STARTED;
        r.slot_index           = 3'(free_slot);
      end
    end else begin
      r.slot_index = 3'(hit);
      sum          = entry_count[hit] + flen;
      // the sequence number does not wrap: the last one has no successor
      if (entry_seq[hit] == SEQ_LAST || int'(seq) != int'(entry_seq[hit]) + 1) begin
        r.verdict = V_ORDER;
      end else if (sum > entry_total[hit]) begin
        r.verdict = V_OVERFLOW;
      end else begin
        r.write_offset   = entry_count[hit];
        entry_seq[hit]   = seq;
        entry_count[hit] = sum[15:0];
        if (sum == entry_total[hit]) begin
          entry_busy[hit] = 1'b0;
          r.verdict       = V_COMPLETED;
          r.deliver_len   = entry_total[hit];
        end else begin
          r.verdict = V_APPENDED;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count_o++;
    $display("[%0t] result %0d: %s", $time, checked_o, what);
  endtask

  // Compare each taken result with the oldest prediction, then queue new ones
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        checked_o++;
        if (pending_results.size() == 0) begin
          report_mismatch("result arrived with no fragment outstanding");
        end else begin
          want = pending_results.pop_front();
          if (verdict_i !== want.verdict)
            report_mismatch($sformatf("verdict %s, predicted %s",
                                      verdict_i.name(), want.verdict.name()));
          if (slot_index_i !== want.slot_index)
            report_mismatch($sformatf("slot_index %0d, predicted %0d",
                                      slot_index_i, want.slot_index));
          if (write_offset_i !== want.write_offset)
            report_mismatch($sformatf("write_offset %0d, predicted %0d",
                                      write_offset_i, want.write_offset));
          if (deliver_len_i !== want.deliver_len)
            report_mismatch($sformatf("deliver_len %0d, predicted %0d",
                                      deliver_len_i, want.deliver_len));
        end
      end
      if (in_valid_i && !in_stall_i)
        pending_results.push_back(predict_fragment(message_id_i, origin_addr_i, frag_seq_i,
                                                   total_len_i, frag_len_i));
      outstanding_o = pending_results.size();
    end
  end

endmodule

// ===== sim/tb_fragment_reassembly_tracker.sv =====
`timescale 1ns / 1ps

module tb_fragment_reassembly_tracker;
  import frt_pkg::*;

  localparam int unsigned SLOTS        = 8;
  localparam int          RANDOM_ITEMS = 740;
  localparam int          NUM_MSGS     = 11;
  localparam int          HOLD_CYCLES  = 60;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 3 * (SLOTS + 2);

  // One message being cut into fragments by the stimulus
  typedef struct {
    bit [15:0] id;
    bit [15:0] org;
    bit [15:0] total;
    bit [15:0] sent;
    bit [7:0]  next_seq;
    bit        active;
  } msg_ctx_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] message_id_i;
  logic [15:0] origin_addr_i;
  logic [7:0]  frag_seq_i;
  logic [15:0] total_len_i;
  logic [7:0]  frag_len_i;
  logic        out_valid_o;
  logic        out_stall_i;
  verdict_e    verdict_o;
  logic [2:0]  slot_index_o;
  logic [15:0] write_offset_o;
  logic [15:0] deliver_len_o;

  int       mismatches;
  int       outstanding;
  int       checked;
  int       sent_count  = 0;
  int       cycle_count = 0;
  bit       steady      = 1'b0;
  bit       hold_start  = 1'b0;
  msg_ctx_t msgs [NUM_MSGS];

  fragment_reassembly_tracker #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .message_id_i   (message_id_i),
    .origin_addr_i  (origin_addr_i),
    .frag_seq_i     (frag_seq_i),
    .total_len_i    (total_len_i),
    .frag_len_i     (frag_len_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .verdict_o      (verdict_o),
    .slot_index_o   (slot_index_o),
    .write_offset_o (write_offset_o),
    .deliver_len_o  (deliver_len_o)
  );

  reassembly_checker #(
    .SLOTS(SLOTS)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .message_id_i     (message_id_i),
    .origin_addr_i    (origin_addr_i),
    .frag_seq_i       (frag_seq_i),
    .total_len_i      (total_len_i),
    .frag_len_i       (frag_len_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .verdict_i        (verdict_o),
    .slot_index_i     (slot_index_o),
    .write_offset_i   (write_offset_o),
    .deliver_len_i    (deliver_len_o),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding),
    .checked_o        (checked)
  );

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
      $display("tb_fragment_reassembly_tracker: done, errors");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request, none while steady
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_start) begin
        hold_start  = 1'b0;
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_stall_i = !steady && ($urandom_range(99) < 27);
      end
    end
  end

  function automatic item_t frag(input bit [15:0] id, input bit [15:0] org,
                                 input bit [7:0] seq, input bit [15:0] tot,
                                 input bit [7:0] flen);
    item_t f;
    f.message_id  = id;
    f.origin_addr = org;
    f.frag_seq    = seq;
    f.total_len   = tot;
    f.frag_len    = flen;
    return f;
  endfunction

  // Offer one item after a random gap and hold it until taken; entered and left at negedge
  task automatic send_fragment(input item_t f);
    while (!steady && $urandom_range(99) < 27) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    message_id_i  = f.message_id;
    origin_addr_i = f.origin_addr;
    frag_seq_i    = f.frag_seq;
    total_len_i   = f.total_len;
    frag_len_i    = f.frag_len;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic run_directed();
    // whole messages, a fragment with no start, a start longer than its total
    send_fragment(frag(16'hFFFF, 16'hFFFF, 8'd0, 16'd0, 8'd0));
    send_fragment(frag(16'h1234, 16'hFFFF, 8'd0, 16'd128, 8'd128));
    send_fragment(frag(16'h0001, 16'h0002, 8'd5, 16'd100, 8'd10));
    send_fragment(frag(16'h0003, 16'h0004, 8'd0, 16'd10, 8'd20));
    // one message: start, append, wrong sequence, count overflow, complete
    send_fragment(frag(16'h0001, 16'h0002, 8'd0, 16'd300, 8'd100));
    send_fragment(frag(16'h0001, 16'h0002, 8'd1, 16'd300, 8'd100));
    send_fragment(frag(16'h0001, 16'h0002, 8'd3, 16'd300, 8'd10));
    send_fragment(frag(16'h0001, 16'h0002, 8'd2, 16'd300, 8'd101));
    send_fragment(frag(16'h0001, 16'h0002, 8'd2, 16'd300, 8'd100));
    // fill every slot, overflow the table, free a middle slot and reuse it
    for (int i = 0; i < SLOTS; i++)
      send_fragment(frag(16'h0100 + i, (i == 7) ? 16'hFFFF : 16'h0010, 8'd0, 16'd2, 8'd1));
    send_fragment(frag(16'h0108, 16'h0010, 8'd0, 16'd2, 8'd1));
    send_fragment(frag(16'h0103, 16'h0010, 8'd1, 16'd2, 8'd1));
    send_fragment(frag(16'h0108, 16'h0010, 8'd0, 16'd2, 8'd1));
    // close the rest
    for (int i = 0; i <= SLOTS; i++)
      if (i != 3)
        send_fragment(frag(16'h0100 + i, (i == 7) ? 16'hFFFF : 16'h0010, 8'd1, 16'd2, 8'd1));
  endtask

  // Run one message up to the last sequence number, then probe past it
  task automatic run_long_message();
    send_fragment(frag(16'hA5C3, 16'h5A3C, 8'd0, 16'hFFFF, 8'd1));
    for (int k = 1; k <= 255; k++)
      send_fragment(frag(16'hA5C3, 16'h5A3C, 8'(k), 16'hFFFF, 8'd255));
    send_fragment(frag(16'hA5C3, 16'h5A3C, 8'd0, 16'hFFFF, 8'd0));
    send_fragment(frag(16'hA5C3, 16'h5A3C, 8'd255, 16'hFFFF, 8'd0));
  endtask

  // Mostly in-order fragments of interleaved messages, the rest broken or noise
  task automatic random_fragment(output item_t f);
    int      c;
    int      r;
    int      remaining;
    int      hi;
    bit [7:0] s;
    c         = $urandom_range(NUM_MSGS - 1);
    r         = $urandom_range(99);
    remaining = msgs[c].total - msgs[c].sent;
    f         = frag(msgs[c].id, msgs[c].org, 8'd0, msgs[c].total, 8'd0);
    if (r < 75 && !msgs[c].active) begin
      msgs[c].id    = $urandom;
      msgs[c].org   = $urandom;
      msgs[c].total = $urandom_range(1, 900);
      hi            = (msgs[c].total > 128) ? 128 : msgs[c].total - 1;
      f             = frag(msgs[c].id, msgs[c].org, 8'd0, msgs[c].total, $urandom_range(0, hi));
      if (msgs[c].total <= 255 && $urandom_range(9) == 0) f.frag_len = msgs[c].total;
      msgs[c].sent     = f.frag_len;
      msgs[c].next_seq = 8'd1;
      msgs[c].active   = (f.frag_len != msgs[c].total);
    end else if (r < 75) begin
      f.frag_seq = msgs[c].next_seq;
      f.frag_len = $urandom_range(0, 128);
      if (f.frag_len > remaining) f.frag_len = remaining;
      if (remaining <= 255 && $urandom_range(3) == 0) f.frag_len = remaining;
      msgs[c].sent += f.frag_len;
      msgs[c].next_seq++;
      if (msgs[c].sent == msgs[c].total) msgs[c].active = 1'b0;
    end else if (r < 85 && msgs[c].active) begin
      if (r < 80 || remaining >= 255) begin
        do s = $urandom_range(1, 255); while (s == msgs[c].next_seq);
        f.frag_seq = s;
        f.frag_len = $urandom_range(0, 255);
      end else begin
        f.frag_seq = msgs[c].next_seq;
        f.frag_len = $urandom_range(remaining + 1, 255);
      end
    end else if (r < 90) begin
      f           = frag($urandom, $urandom, 8'd0, $urandom_range(0, 255), 8'd0);
      f.frag_len  = f.total_len[7:0];
    end else if (r < 94) begin
      f           = frag($urandom, $urandom, 8'd0, $urandom_range(0, 254), 8'd0);
      f.frag_len  = $urandom_range(f.total_len + 1, 255);
    end else begin
      f = frag($urandom, $urandom, $urandom_range(1, 255), $urandom, $urandom_range(0, 255));
    end
  endtask

  initial begin
    item_t f;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    message_id_i  = '0;
    origin_addr_i = '0;
    frag_seq_i    = '0;
    total_len_i   = '0;
    frag_len_i    = '0;
    for (int m = 0; m < NUM_MSGS; m++) msgs[m] = '{default: 0};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    run_directed();
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) hold_start = 1'b1;
      steady = (n >= 250 && n < 370);
      if (n == 450) wait_drained();
      if (n == 600) run_long_message();
      random_fragment(f);
      send_fragment(f);
    end

    // drain, then give a stray late result time to show up
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Covered %0d fragment headers: all verdicts, a full table, interleaved messages,",
             sent_count);
    $display("and a message run to the last sequence number; %0d results compared.", checked);
    if (mismatches == 0)
      $display("tb_fragment_reassembly_tracker: done, clean");
    else
      $display("tb_fragment_reassembly_tracker: done, errors");
    $finish;
  end

endmodule
